>>> rtl/core/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg : shared types and constants of the smoothed RMS amplitude meter
// Widths of the record arithmetic, register codes and the queue entry type.
// ----------------------------------------------------------------------------
package srm_pkg;

  // record limits
  localparam int MAX_WINDOW  = 64;
  localparam int MAX_SAMPLES = 4096;

  // field widths
  localparam int SMP_W  = 8;
  localparam int WLEN_W = 7;
  localparam int VPD_W  = 14;
  localparam int OUT_W  = 27;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = VPD_W;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VPD    = 1'b1;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd15;
  localparam logic [VPD_W-1:0]  VPD_RESET  = 14'd1000;

  // delay line ring
  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int RING_D = 1 << AW;

  // record arithmetic
  localparam int WE_W   = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SMP_W + WE_W;
  localparam int SQ_W   = 2 * (SUM_W - 1) + 1;
  localparam int T_W    = SUM_W + CNT_W - 1;
  localparam int TM_W   = T_W - 1;
  localparam int Q_W    = 2 * (SUM_W - 1) + CNT_W - 1;
  localparam int QL_W   = Q_W / 2;
  localparam int QH_W   = Q_W - QL_W;
  localparam int K_W    = VPD_W + 10;
  localparam int K_MULT = 625;
  localparam int D_W    = CNT_W + WE_W + 4;
  localparam int DEN_W  = D_W + 1;
  localparam int TK_W   = TM_W + K_W;
  localparam int TT_W   = 2 * TM_W;
  localparam int MQ_W   = CNT_W + Q_W;
  localparam int V_W    = MQ_W + 11;
  localparam int S_W    = V_W / 2;
  localparam int SK_W   = S_W + K_W;
  localparam int NUM_W  = SK_W + 1;

  // queue between front and back
  localparam int FIFO_D  = 4;
  localparam int FIFO_AW = $clog2(FIFO_D);

  typedef struct packed {
    logic                    acc;
    logic                    fin;
    logic                    short_rec;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
    logic [CNT_W-1:0]        cnt;
    logic [WE_W-1:0]         win;
  } srm_entry_t;

endpackage

>>> rtl/core/srm_in_if.sv
// ----------------------------------------------------------------------------
// srm_in_if : sample channel
// Valid/ready channel carrying one scope sample and its end-of-record mark.
// ----------------------------------------------------------------------------
interface srm_in_if import srm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  logic                    last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

>>> rtl/core/srm_out_if.sv
// ----------------------------------------------------------------------------
// srm_out_if : result channel
// Valid/ready channel carrying one record result.
// ----------------------------------------------------------------------------
interface srm_out_if import srm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OUT_W-1:0]        amplitude_uv;
  logic signed [OUT_W-1:0] mean_uv;
  logic                    too_short;

  modport source (output valid, amplitude_uv, mean_uv, too_short, input ready);
  modport sink   (input valid, amplitude_uv, mean_uv, too_short, output ready);
endinterface

>>> rtl/core/srm_front.sv
// ----------------------------------------------------------------------------
// srm_front : sample intake and boxcar smoothing
// Keeps the delay line as a ring memory and a running window sum, classifies
// each sample and pushes accumulate / finish entries with the squared sum.
// ----------------------------------------------------------------------------
module srm_front import srm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  srm_in_if.sink          in_ch,
  input  logic [WE_W-1:0] win_eff,
  input  logic            q_full,
  output logic            q_push,
  output srm_entry_t      q_data
);

  typedef enum logic [1:0] {F_RUN, F_RECALC, F_REFRESH} fstate_t;

  fstate_t                 state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [WE_W-1:0]         wused_r, wused_nxt;
  logic [WE_W-1:0]         j_r, j_nxt;
  logic                    pend_r, pend_nxt;
  logic                    s1_valid_r, s1_valid_nxt;
  srm_entry_t              s1_r, s1_nxt;

  logic signed [SMP_W-1:0] ring [RING_D];
  logic signed [SMP_W-1:0] rd_data_r;
  logic [AW-1:0]           ra, wa;
  logic                    mem_we;

  logic                    s1_free, accept, keep, acc;
  logic signed [SMP_W-1:0] leave;
  logic signed [SUM_W-1:0] sum_upd, sum_new;
  logic [CNT_W-1:0]        cnt_upd, cnt_new;
  logic signed [2*SUM_W-1:0] sq_full;

  // handshake and stage hand-off
  assign q_push      = s1_valid_r && !q_full;
  assign s1_free     = !s1_valid_r || q_push;
  assign in_ch.ready = (state_r == F_RUN) && (wused_r == win_eff) && s1_free;
  assign accept      = in_ch.valid && in_ch.ready;

  // sliding window update: add newest, drop the one leaving the window
  assign keep    = (cnt_r != CNT_W'(MAX_SAMPLES));
  assign leave   = (cnt_r >= CNT_W'(wused_r)) ? rd_data_r : '0;
  assign sum_upd = sum_r + SUM_W'(in_ch.sample) - SUM_W'(leave);
  assign cnt_upd = cnt_r + CNT_W'(1);
  assign sum_new = keep ? sum_upd : sum_r;
  assign cnt_new = keep ? cnt_upd : cnt_r;
  assign acc     = keep && (cnt_upd >= CNT_W'(wused_r));

  assign mem_we = accept && keep;
  assign wa     = cnt_upd[AW-1:0];

  // squared window sum on its way into the queue
  assign sq_full = s1_r.sum * s1_r.sum;
  always_comb begin
    q_data    = s1_r;
    q_data.sq = sq_full[SQ_W-1:0];
  end

  // control
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    wused_nxt    = wused_r;
    j_nxt        = j_r;
    pend_nxt     = 1'b0;
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;

    if (s1_free) begin
      s1_valid_nxt = 1'b0;
    end

    case (state_r)
      F_RUN: begin
        if (accept) begin
          s1_valid_nxt     = acc || in_ch.last;
          s1_nxt.acc       = acc;
          s1_nxt.fin       = in_ch.last;
          s1_nxt.short_rec = (cnt_new < CNT_W'(wused_r));
          s1_nxt.sum       = sum_new;
          s1_nxt.sq        = '0;
          s1_nxt.cnt       = cnt_new;
          s1_nxt.win       = wused_r;
          if (in_ch.last) begin
            cnt_nxt = '0;
            sum_nxt = '0;
          end else begin
            cnt_nxt = cnt_new;
            sum_nxt = sum_new;
          end
        end else if (wused_r != win_eff) begin
          // window changed: rebuild the sum over the new length
          state_nxt = F_RECALC;
          wused_nxt = win_eff;
          sum_nxt   = '0;
          j_nxt     = '0;
        end
      end
      F_RECALC: begin
        if (pend_r) begin
          sum_nxt = sum_r + SUM_W'(rd_data_r);
        end
        if (j_r < wused_r) begin
          pend_nxt = (CNT_W'(j_r) < cnt_r);
          j_nxt    = j_r + WE_W'(1);
        end else begin
          state_nxt = F_REFRESH;
        end
      end
      F_REFRESH: begin
        state_nxt = F_RUN;
      end
      default: begin
        state_nxt = F_RUN;
      end
    endcase
  end

  // read address: entry leaving the window at the next sample, or rebuild tap
  always_comb begin
    if (state_r == F_RECALC) begin
      ra = cnt_r[AW-1:0] - j_r[AW-1:0];
    end else begin
      ra = cnt_nxt[AW-1:0] + AW'(1) - wused_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_RUN;
      cnt_r      <= '0;
      sum_r      <= '0;
      wused_r    <= '0;
      j_r        <= '0;
      pend_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      wused_r    <= wused_nxt;
      j_r        <= j_nxt;
      pend_r     <= pend_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // delay line ring, write-through on a same-address read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wa] <= in_ch.sample;
    end
    if (mem_we && (wa == ra)) begin
      rd_data_r <= in_ch.sample;
    end else begin
      rd_data_r <= ring[ra];
    end
  end

endmodule

>>> rtl/core/srm_fifo.sv
// ----------------------------------------------------------------------------
// srm_fifo : short queue between front and back
// Holds accumulate and finish requests so each side can stall on its own.
// ----------------------------------------------------------------------------
module srm_fifo import srm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  srm_entry_t wdata,
  input  logic       pop,
  output srm_entry_t rdata,
  output logic       full,
  output logic       empty
);

  srm_entry_t         slot_r [FIFO_D];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full  = (cnt_r == (FIFO_AW+1)'(FIFO_D));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == FIFO_AW'(FIFO_D - 1)) ? '0 : wp_r + FIFO_AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == FIFO_AW'(FIFO_D - 1)) ? '0 : rp_r + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (FIFO_AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (FIFO_AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

>>> rtl/core/srm_div.sv
// ----------------------------------------------------------------------------
// srm_div : restoring divider
// Unsigned quotient, one bit per cycle; done pulses with the result ready.
// ----------------------------------------------------------------------------
module srm_div import srm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r, den_r;
  logic [NUM_W-1:0]  nq_r;
  logic [DEN_W:0]    trial, diff;
  logic              qbit;

  // one quotient bit: shift in the next numerator bit, subtract if it fits
  assign trial = {rem_r, nq_r[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  assign done = done_r;
  assign quot = nq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      nq_r  <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq_r  <= {nq_r[NUM_W-2:0], qbit};
    end
  end

endmodule

>>> rtl/core/srm_back.sv
// ----------------------------------------------------------------------------
// srm_back : record accumulation and result arithmetic
// Sums window sums and their squares; at record end works out the mean and
// the amplitude with split multiplies, a bit-serial root and the divider.
// ----------------------------------------------------------------------------
module srm_back import srm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [VPD_W-1:0] vpd_mv,
  input  logic             q_empty,
  input  srm_entry_t       q_data,
  output logic             q_pop,
  srm_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    B_IDLE, B_MUL1, B_MUL2, B_SUB, B_ROOT, B_MULS, B_DSTART, B_DWAIT, B_OUT
  } bstate_t;

  bstate_t               state_r;
  logic signed [T_W-1:0] t_r;
  logic [Q_W-1:0]        q_r;
  logic [CNT_W-1:0]      m_r;
  logic [WE_W-1:0]       w_r;
  logic [K_W-1:0]        k_r;
  logic                  tneg_r, short_r, mdone_r;
  logic [TK_W-1:0]       tk_r;
  logic [TT_W-1:0]       tt_r;
  logic [CNT_W+QL_W-1:0] mqlo_r;
  logic [CNT_W+QH_W-1:0] mqhi_r;
  logic [D_W-1:0]        d_r;
  logic [V_W-1:0]        v_r, res_r, bit_r;
  logic [SK_W-1:0]       sk_r;
  logic [OUT_W-1:0]      mean_r, amp_r;

  logic                  ovalid_r, oshort_r;
  logic [OUT_W-1:0]      oamp_r, omean_r;

  logic [T_W-1:0]        tabs;
  logic [TM_W-1:0]       tmag;
  logic [MQ_W-1:0]       mq, dd;
  logic [V_W-1:0]        sq_tmp;
  logic                  div_start, div_done, out_load;
  logic [NUM_W-1:0]      div_num, div_quot;
  logic [DEN_W-1:0]      div_den;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign out_load = (state_r == B_OUT) && (!ovalid_r || out_ch.ready);

  assign tabs = t_r[T_W-1] ? T_W'(-t_r) : T_W'(t_r);
  assign tmag = tabs[TM_W-1:0];

  // m*Q - T*T, never negative in practice but clamped
  assign mq = (MQ_W'(mqhi_r) << QL_W) + MQ_W'(mqlo_r);
  assign dd = (mq > MQ_W'(tt_r)) ? mq - MQ_W'(tt_r) : '0;

  assign sq_tmp = res_r + bit_r;

  // divider operands: mean first, amplitude second
  // amplitude: (s*K + 16d) / 32d taken as ((s*K + 16d) >> 4) / 2d
  assign div_start = (state_r == B_SUB) || (state_r == B_DSTART);
  always_comb begin
    if (state_r == B_SUB) begin
      div_num = NUM_W'(tk_r) + NUM_W'(d_r >> 1);
      div_den = DEN_W'(d_r);
    end else begin
      div_num = (NUM_W'(sk_r) + (NUM_W'(d_r) << 4)) >> 4;
      div_den = {d_r, 1'b0};
    end
  end

  srm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_ch.valid        = ovalid_r;
  assign out_ch.amplitude_uv = oamp_r;
  assign out_ch.mean_uv      = omean_r;
  assign out_ch.too_short    = oshort_r;

  // sequencer, record sums and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      t_r      <= '0;
      q_r      <= '0;
      ovalid_r <= 1'b0;
      mdone_r  <= 1'b0;
    end else begin
      if (ovalid_r && out_ch.ready && !out_load) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            if (q_data.acc) begin
              t_r <= t_r + T_W'(q_data.sum);
              q_r <= q_r + Q_W'(q_data.sq);
            end
            if (q_data.fin) begin
              state_r <= q_data.short_rec ? B_OUT : B_MUL1;
            end
          end
        end
        B_MUL1: state_r <= B_MUL2;
        B_MUL2: state_r <= B_SUB;
        B_SUB: begin
          mdone_r <= 1'b0;
          state_r <= B_ROOT;
        end
        B_ROOT: begin
          if (div_done) begin
            mdone_r <= 1'b1;
          end
          if ((mdone_r || div_done) && (bit_r == '0)) begin
            state_r <= B_MULS;
          end
        end
        B_MULS:   state_r <= B_DSTART;
        B_DSTART: state_r <= B_DWAIT;
        B_DWAIT: begin
          if (div_done) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_load) begin
            ovalid_r <= 1'b1;
            t_r      <= '0;
            q_r      <= '0;
            state_r  <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop && q_data.fin) begin
      short_r <= q_data.short_rec;
      m_r     <= q_data.cnt - CNT_W'(q_data.win) + CNT_W'(1);
      w_r     <= q_data.win;
      k_r     <= K_W'(vpd_mv) * K_W'(K_MULT);
    end
    if (state_r == B_MUL1) begin
      tneg_r <= t_r[T_W-1];
      tk_r   <= TK_W'(tmag) * TK_W'(k_r);
      tt_r   <= TT_W'(tmag) * TT_W'(tmag);
      mqlo_r <= (CNT_W+QL_W)'(m_r) * (CNT_W+QL_W)'(q_r[QL_W-1:0]);
      d_r    <= D_W'(D_W'(m_r) * D_W'(w_r)) << 4;
    end
    if (state_r == B_MUL2) begin
      mqhi_r <= (CNT_W+QH_W)'(m_r) * (CNT_W+QH_W)'(q_r[Q_W-1:QL_W]);
    end
    // integer square root, one result bit a cycle
    if (state_r == B_SUB) begin
      v_r   <= V_W'(dd) << 11;
      res_r <= '0;
      bit_r <= V_W'(1) << (V_W - 2);
    end else if ((state_r == B_ROOT) && (bit_r != '0)) begin
      if (v_r >= sq_tmp) begin
        v_r   <= v_r - sq_tmp;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if ((state_r == B_ROOT) && div_done) begin
      mean_r <= div_quot[OUT_W-1:0];
    end
    if (state_r == B_MULS) begin
      sk_r <= SK_W'(res_r[S_W-1:0]) * SK_W'(k_r);
    end
    if ((state_r == B_DWAIT) && div_done) begin
      amp_r <= div_quot[OUT_W-1:0];
    end
    if (out_load) begin
      oshort_r <= short_r;
      if (short_r) begin
        oamp_r  <= '0;
        omean_r <= '0;
      end else begin
        oamp_r  <= amp_r;
        omean_r <= tneg_r ? (~mean_r + OUT_W'(1)) : mean_r;
      end
    end
  end

endmodule

>>> rtl/core/smoothed_rms_amplitude_meter_core.sv
// ----------------------------------------------------------------------------
// smoothed_rms_amplitude_meter_core : boxcar-smoothed mean / amplitude meter
// Streams signed scope codes, smooths them and reports mean and peak
// amplitude in microvolts at the end of each record.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                               | handshake
//  in_ch    | sink      | sample[7:0] signed, last              | valid/ready
//  out_ch   | source    | amplitude_uv[26:0], mean_uv[26:0] s,  | valid/ready
//           |           | too_short                             |
//  cfg_*    | write     | cfg_idx (0 window, 1 mV/div), data    | cfg_we
//
//  One sample a cycle through the front while the queue has room; a window
//  length change holds the input off while the sum is rebuilt.
//  Record end: the back runs the 57-step mean divide alongside the 32-step
//  root, then the amplitude divide; the 4-deep queue and the front
//  stage take a few more samples meanwhile, then the input stalls.
//  Synchronous active-low reset, no clearing pass. Results wait in an output
//  register; a stalled result holds the back and so fills the queue.
// ----------------------------------------------------------------------------
module smoothed_rms_amplitude_meter_core import srm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  srm_in_if.sink                in_ch,
  srm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WLEN_W-1:0] wlen_r;
  logic [VPD_W-1:0]  vpd_r;
  logic [WE_W-1:0]   win_eff;

  logic              q_push, q_pop, q_full, q_empty;
  srm_entry_t        q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
      vpd_r  <= VPD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW: wlen_r <= cfg_data[WLEN_W-1:0];
        REG_VPD:    vpd_r  <= cfg_data[VPD_W-1:0];
        default:    wlen_r <= wlen_r;
      endcase
    end
  end

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    if (wlen_r == '0) begin
      win_eff = WE_W'(1);
    end else if (WE_W'(wlen_r) > WE_W'(MAX_WINDOW)) begin
      win_eff = WE_W'(MAX_WINDOW);
    end else begin
      win_eff = WE_W'(wlen_r);
    end
  end

  srm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .win_eff (win_eff),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  srm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  srm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .vpd_mv  (vpd_r),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/tb_smoothed_rms_amplitude_meter_core.sv
// ----------------------------------------------------------------------------
// tb_smoothed_rms_amplitude_meter_core : self-checking bench of the meter
// Drives scope records through the sample channel with random gaps and back
// pressure. Each record result is compared with a software model of the
// smoothing, mean and amplitude arithmetic. Runs several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_smoothed_rms_amplitude_meter_core;
  import srm_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] amp;
    logic [OUT_W-1:0] mean;
    logic             short_rec;
  } meter_res_t;

  typedef struct {
    logic [SMP_W-1:0] smp;
    logic             lst;
    logic             chk;   // fixed result typed in
    meter_res_t       res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  srm_in_if  in_ch ();
  srm_out_if out_ch ();

  smoothed_rms_amplitude_meter_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // model state
  logic [6:0]  m_wlen;
  logic [13:0] m_vpd;
  int          m_line [MAX_WINDOW];
  int          m_cnt;
  longint      m_tsum;
  longint unsigned m_qsum;

  meter_res_t  pending_results [$];
  meter_res_t  typed_results [$];
  logic        typed_flag [$];
  int          fails;
  int          cycles;
  bit          hold_off;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("smoothed_rms_amplitude_meter_core: mismatch");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void clear_record();
    foreach (m_line[i]) m_line[i] = 0;
    m_cnt  = 0;
    m_tsum = 0;
    m_qsum = 0;
  endfunction

  // advance the model by one sample; returns 1 with a result at record end
  function automatic bit meter_predict(logic [7:0] smp, logic lst, output meter_res_t r);
    int w, s;
    longint unsigned m, k, d, tm, q, mq, t2, dd, sq, amp;
    w = (m_wlen < 1) ? 1 : ((m_wlen > MAX_WINDOW) ? MAX_WINDOW : m_wlen);
    if (m_cnt < MAX_SAMPLES) begin
      for (int i = MAX_WINDOW - 1; i > 0; i--) m_line[i] = m_line[i-1];
      m_line[0] = $signed(smp);
      m_cnt++;
      s = 0;
      for (int i = 0; i < w; i++) s += m_line[i];
      if (m_cnt >= w) begin
        m_tsum += s;
        m_qsum += longint'(s) * longint'(s);
      end
    end
    r = '{amp: '0, mean: '0, short_rec: 1'b0};
    if (!lst) return 0;
    if (m_cnt < w) begin
      r.short_rec = 1'b1;
    end else begin
      m  = m_cnt - w + 1;
      k  = m_vpd * 625;
      d  = 16 * m * w;
      tm = (m_tsum < 0) ? -m_tsum : m_tsum;
      q  = (tm * k + d / 2) / d;
      mq = m * m_qsum;
      t2 = tm * tm;
      dd = (mq > t2) ? mq - t2 : 0;
      sq = int_sqrt((dd * 2) << 10);
      amp = (sq * k + 16 * d) / (32 * d);
      if (m_tsum < 0) q = -q;
      r.amp  = amp[OUT_W-1:0];
      r.mean = q[OUT_W-1:0];
    end
    clear_record();
    return 1;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW) m_wlen = val[6:0];
    else m_vpd = val;
    // rebuild after a window change
    repeat (MAX_WINDOW + 4) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  // offer one request, wait for acceptance, record the expectation
  task automatic send_sample(logic [7:0] smp, logic lst, logic chk, meter_res_t fixed,
                             bit gaps);
    meter_res_t r;
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    in_ch.last   <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (meter_predict(smp, lst, r)) begin
      pending_results.push_back(r);
      typed_flag.push_back(chk);
      typed_results.push_back(fixed);
    end
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // random record: mostly sensible lengths, a few short ones
  task automatic send_record(bit gaps);
    int n, mode;
    logic [7:0] base;
    meter_res_t z;
    z = '{amp: '0, mean: '0, short_rec: 1'b0};
    mode = $urandom_range(0, 9);
    n = (mode == 0) ? $urandom_range(1, 8) : $urandom_range(10, 90);
    base = 8'($urandom);
    for (int i = 0; i < n; i++) begin
      logic [7:0] v;
      v = (mode < 3) ? 8'($urandom) : 8'(base + $urandom_range(0, 20) - 10);
      send_sample(v, i == n - 1, 1'b0, z, gaps);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      meter_res_t e;
      if (pending_results.size() == 0) begin
        $error("too_short: unexpected result, actual %0d", out_ch.too_short);
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (typed_flag.pop_front()) e = typed_results.pop_front();
        else void'(typed_results.pop_front());
        if (out_ch.amplitude_uv !== e.amp) begin
          $error("amplitude_uv: expected %0d actual %0d", e.amp, out_ch.amplitude_uv);
          fails++;
        end
        if (out_ch.mean_uv !== e.mean) begin
          $error("mean_uv: expected %0d actual %0d", $signed(e.mean), out_ch.mean_uv);
          fails++;
        end
        if (out_ch.too_short !== e.short_rec) begin
          $error("too_short: expected %0d actual %0d", e.short_rec, out_ch.too_short);
          fails++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int st;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (800) @(posedge clk);
        hold_off = 0;
      end
      st = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) st = 0;
      if (st != 0) begin
        out_ch.ready <= 1'b0;
        repeat (st) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    dir_row_t rows [$];
    meter_res_t z, sh;
    int wl [6];
    int vp [6];
    fails = 0; cycles = 0; hold_off = 0;
    z  = '{amp: '0, mean: '0, short_rec: 1'b0};
    sh = '{amp: '0, mean: '0, short_rec: 1'b1};
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.sample = '0; in_ch.last = 1'b0;
    m_wlen = WLEN_RESET; m_vpd = VPD_RESET;
    clear_record();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short record after reset, extremes, flat records
    rows.push_back('{8'h7f, 1'b1, 1'b1, sh});
    for (int i = 0; i < 15; i++) rows.push_back('{8'h80, i == 14, 1'b0, z});
    for (int i = 0; i < 8; i++) rows.push_back('{i[0] ? 8'h7f : 8'h80, i == 7, 1'b0, z});
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].lst, rows[i].chk, rows[i].res, 0);
    idle_input();
    drain();

    // window 1 and scale extremes, window 0 and oversize windows
    wl = '{1, 0, 64, 127, 2, 15};
    vp = '{10000, 1, 0, 10000, 16383, 1000};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_WINDOW, CFG_DATA_W'(wl[p]));
      write_reg(REG_VPD, CFG_DATA_W'(vp[p]));
      send_sample(8'h7f, 1'b0, 1'b0, z, 0);
      send_sample(8'h80, 1'b0, 1'b0, z, 0);
      send_sample(8'h7f, 1'b1, 1'b0, z, 0);
      send_record(1);
      idle_input();
      drain();
    end

    // long hold-off with the sender pushing back-to-back
    write_reg(REG_WINDOW, CFG_DATA_W'(4));
    hold_off = 1;
    for (int rec = 0; rec < 8; rec++) begin
      for (int i = 0; i < 3; i++) send_sample(8'($urandom), i == 2, 1'b0, z, 0);
    end
    idle_input();
    drain();

    // random phase with varied registers
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_WINDOW, CFG_DATA_W'($urandom_range(0, 127)));
      write_reg(REG_VPD, CFG_DATA_W'($urandom_range(0, 16383)));
      send_record($urandom_range(0, 2) != 0);
      idle_input();
      drain();
    end

    if (fails == 0 && pending_results.size() == 0)
      $display("smoothed_rms_amplitude_meter_core: match");
    else
      $display("smoothed_rms_amplitude_meter_core: mismatch");
    $finish;
  end

endmodule

>>> files.f
rtl/core/srm_pkg.sv
rtl/core/srm_in_if.sv
rtl/core/srm_out_if.sv
rtl/core/srm_front.sv
rtl/core/srm_fifo.sv
rtl/core/srm_div.sv
rtl/core/srm_back.sv
rtl/core/smoothed_rms_amplitude_meter_core.sv
tb/tb_smoothed_rms_amplitude_meter_core.sv
